[rtl/ssls_pkg.sv]
// Shared types and constants for the shortest/longest span set.
package ssls_pkg;

   localparam int CAPACITY     = 1024;
   localparam int ADDR_W       = $clog2(CAPACITY);
   localparam int CNT_W        = $clog2(CAPACITY + 1);
   localparam int VAL_W        = 32;
   localparam int MIN_FOR_SPAN = 2;

   localparam logic [VAL_W-1:0] SIGN_FLIP = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic [CNT_W-1:0] CAP_LIMIT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(1024);
   localparam logic [CNT_W-1:0] SPAN_MIN  = CNT_W'(MIN_FOR_SPAN);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_DONE
   } ssls_state_type;

   // One stored value presented to the gap unit with the probe it is compared to.
   typedef struct packed {
      logic             data_vld;
      logic [VAL_W-1:0] probe;
      logic [VAL_W-1:0] data;
   } ssls_gap_req_type;

endpackage

[rtl/ssls_gap_unit.sv]
// Shared gap unit: absolute difference, then running minimum of the gap.
module ssls_gap_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  ssls_pkg::ssls_gap_req_type    gap_req,
   output logic                          busy,
   output logic [ssls_pkg::VAL_W-1:0]    smallest_gap
);

   logic [ssls_pkg::VAL_W-1:0] gap_ff, gap_in;
   logic                       gap_vld_ff;
   logic [ssls_pkg::VAL_W-1:0] min_gap_ff;
   logic [ssls_pkg::VAL_W-1:0] diff_ab, diff_ba;

   // Values carry the sign bit flipped, so unsigned order is signed order.
   assign diff_ab = gap_req.probe - gap_req.data;
   assign diff_ba = gap_req.data - gap_req.probe;
   assign gap_in  = (gap_req.probe >= gap_req.data) ? diff_ab : diff_ba;

   always_ff @(posedge clock) begin
      gap_ff <= gap_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_vld_ff <= 1'b0;
         min_gap_ff <= '1;
      end else begin
         gap_vld_ff <= gap_req.data_vld;
         if (gap_vld_ff && (gap_ff < min_gap_ff)) begin
            min_gap_ff <= gap_ff;
         end
      end
   end

   assign busy         = gap_vld_ff;
   assign smallest_gap = min_gap_ff;

endmodule

[rtl/set_shortest_longest_span_top.sv]
// Top level: bounded integer set with shortest and longest span.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_value
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_status, rsp_held_count, rsp_span_valid, spans
//  csr     | in        | csr_wr_en            | csr_wr_data (capacity)
//
// An accepted number is compared with every number already held: the value memory has one
// read port, so the scan reads one stored value per cycle, then drains a two-stage compare
// pipeline before the set is updated. A rejected number goes straight to the output register.
// Reset is synchronous; the value memory needs no clearing since only written entries are
// read. The next item is taken while a result still waits in the output register; a stalled
// result blocks only the finish of the following item.
module set_shortest_longest_span_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [ssls_pkg::VAL_W-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_status,
   output logic [ssls_pkg::CNT_W-1:0]    rsp_held_count,
   output logic                          rsp_span_valid,
   output logic [ssls_pkg::VAL_W-1:0]    rsp_shortest_span,
   output logic [ssls_pkg::VAL_W-1:0]    rsp_longest_span,
   input  logic                          csr_wr_en,
   input  logic [ssls_pkg::CNT_W-1:0]    csr_wr_data
);

   ssls_pkg::ssls_state_type   state_ff, state_in;
   logic [ssls_pkg::CNT_W-1:0] capacity_ff;
   logic [ssls_pkg::CNT_W-1:0] count_ff;
   logic [ssls_pkg::CNT_W-1:0] addr_ff;
   logic [ssls_pkg::VAL_W-1:0] probe_ff;
   logic                       status_ff;
   logic [ssls_pkg::VAL_W-1:0] min_ff;
   logic [ssls_pkg::VAL_W-1:0] max_ff;
   logic                       rd_vld_ff;
   logic [ssls_pkg::VAL_W-1:0] mem_q_ff;
   logic [ssls_pkg::VAL_W-1:0] mem [ssls_pkg::CAPACITY];

   logic                       rsp_valid_ff;
   logic                       rsp_status_ff;
   logic [ssls_pkg::CNT_W-1:0] rsp_count_ff;
   logic                       rsp_span_vld_ff;
   logic [ssls_pkg::VAL_W-1:0] rsp_short_ff;
   logic [ssls_pkg::VAL_W-1:0] rsp_long_ff;

   logic [ssls_pkg::CNT_W-1:0] limit;
   logic                       full;
   logic                       accept;
   logic                       rd_issue;
   logic                       mem_wr;
   logic                       out_load;
   logic                       scan_done;
   logic                       span_vld;
   logic                       gap_busy;
   logic [ssls_pkg::VAL_W-1:0] smallest_gap;
   ssls_pkg::ssls_gap_req_type gap_req;

   assign limit  = (capacity_ff > ssls_pkg::CAP_LIMIT) ? ssls_pkg::CAP_LIMIT : capacity_ff;
   assign full   = (count_ff >= limit);
   assign accept = req_valid && req_ready;
   assign scan_done = (addr_ff == count_ff) && !rd_vld_ff && !gap_busy;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ssls_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = full ? ssls_pkg::ST_DONE : ssls_pkg::ST_SCAN;
            end
         end
         ssls_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = ssls_pkg::ST_UPDATE;
            end
         end
         ssls_pkg::ST_UPDATE: begin
            state_in = ssls_pkg::ST_DONE;
         end
         ssls_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ssls_pkg::ST_IDLE;
            end
         end
         default: state_in = ssls_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      rd_issue  = 1'b0;
      mem_wr    = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ssls_pkg::ST_IDLE:   req_ready = 1'b1;
         ssls_pkg::ST_SCAN:   rd_issue  = (addr_ff < count_ff);
         ssls_pkg::ST_UPDATE: mem_wr    = 1'b1;
         ssls_pkg::ST_DONE:   out_load  = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ssls_pkg::ST_IDLE;
         capacity_ff <= ssls_pkg::CAP_RESET;
         count_ff    <= '0;
         min_ff      <= '0;
         max_ff      <= '0;
         addr_ff     <= '0;
         rd_vld_ff   <= 1'b0;
         status_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_issue;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (accept) begin
            status_ff <= full;
            addr_ff   <= '0;
         end else if (rd_issue) begin
            addr_ff <= addr_ff + 1'b1;
         end
         if (mem_wr) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == '0) begin
               min_ff <= probe_ff;
               max_ff <= probe_ff;
            end else begin
               if (probe_ff < min_ff) min_ff <= probe_ff;
               if (probe_ff > max_ff) max_ff <= probe_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         probe_ff <= req_value ^ ssls_pkg::SIGN_FLIP;
      end
   end

   // value memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[count_ff[ssls_pkg::ADDR_W-1:0]] <= probe_ff;
      end
      mem_q_ff <= mem[addr_ff[ssls_pkg::ADDR_W-1:0]];
   end

   assign gap_req.data_vld = rd_vld_ff;
   assign gap_req.probe    = probe_ff;
   assign gap_req.data     = mem_q_ff;

   ssls_gap_unit u_gap (
      .clock        (clock),
      .reset        (reset),
      .gap_req      (gap_req),
      .busy         (gap_busy),
      .smallest_gap (smallest_gap)
   );

   assign span_vld = (count_ff >= ssls_pkg::SPAN_MIN);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status_ff   <= status_ff;
         rsp_count_ff    <= count_ff;
         rsp_span_vld_ff <= span_vld;
         rsp_short_ff    <= span_vld ? smallest_gap : '0;
         rsp_long_ff     <= span_vld ? (max_ff - min_ff) : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_held_count    = rsp_count_ff;
   assign rsp_span_valid    = rsp_span_vld_ff;
   assign rsp_shortest_span = rsp_short_ff;
   assign rsp_longest_span  = rsp_long_ff;

endmodule

[rtl/ssls_checker.sv]
// Port-level checker for the span set, bound to the top level.
module ssls_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_status,
   input logic [ssls_pkg::CNT_W-1:0]    rsp_held_count,
   input logic                          rsp_span_valid,
   input logic [ssls_pkg::VAL_W-1:0]    rsp_shortest_span,
   input logic [ssls_pkg::VAL_W-1:0]    rsp_longest_span
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_status, rsp_held_count, rsp_span_valid,
                  rsp_shortest_span, rsp_longest_span}))
      else $error("result dropped or changed while stalled");

   a_busy_after_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after an accepted item");

   a_span_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_span_valid == (rsp_held_count >= ssls_pkg::SPAN_MIN)))
      else $error("span valid flag disagrees with count");

   a_span_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_span_valid |->
         (rsp_shortest_span == '0) && (rsp_longest_span == '0))
      else $error("spans not zero with too few numbers");

   a_span_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_span_valid |-> (rsp_shortest_span <= rsp_longest_span))
      else $error("shortest span exceeds longest span");

endmodule

bind set_shortest_longest_span_top ssls_checker u_ssls_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_held_count    (rsp_held_count),
   .rsp_span_valid    (rsp_span_valid),
   .rsp_shortest_span (rsp_shortest_span),
   .rsp_longest_span  (rsp_longest_span)
);
